// ===== rtl/cartesian_to_spherical_projector_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Cartesian-to-spherical projector
// Each macro checks a property clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_PROJECTOR_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_PROJECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define C2S_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define C2S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define C2S_ASSERT_IMP(lbl, ante, cons, msg)
`define C2S_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/c2s_pkg.sv =====
// ----------------------------------------------------------------------------
// c2s_pkg
// Widths, register codes, cell payload types and tables of the projector.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int COEF_FRAC    = 14;
  localparam int ROW_WIDTH    = 3 * COEF_WIDTH;
  localparam int SHIFT_WIDTH  = 24;
  localparam int CFG_WIDTH    = ROW_WIDTH;
  localparam int IDX_WIDTH    = 3;
  localparam int PROD_WIDTH   = COEF_WIDTH + COORD_WIDTH;
  localparam int SUM_WIDTH    = PROD_WIDTH + 2;
  localparam int TSUM_WIDTH   = SUM_WIDTH - COEF_FRAC + 1;
  localparam int SQ_WIDTH     = 2 * COORD_WIDTH;
  localparam int RAD_WIDTH    = 62;
  localparam int SQRT_STEPS   = RAD_WIDTH / 2;
  localparam int ROOT_WIDTH   = SQRT_STEPS;
  localparam int REM_WIDTH    = ROOT_WIDTH + 1;
  localparam int VEC_WIDTH    = 57;
  localparam int CORD_WIDTH   = 34;
  localparam int TURN_WIDTH   = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int STEP_WIDTH   = 5;
  localparam int BL_WIDTH     = 6;
  localparam int NORM_BL      = 30;

  localparam int COORD_MAX  = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int COORD_MIN  = -(2 ** (COORD_WIDTH - 1));
  localparam int ROUND_HALF = 2 ** (COEF_FRAC - 1);

  localparam logic [TURN_WIDTH-1:0] HALF_TURN   = {1'b1, {(TURN_WIDTH - 1){1'b0}}};
  localparam logic [TURN_WIDTH-1:0] ANGLE_ROUND =
    TURN_WIDTH'(64'd1 << (TURN_WIDTH - 1 - ANGLE_WIDTH));

  localparam logic [COEF_WIDTH-1:0] UNITY = COEF_WIDTH'(2 ** COEF_FRAC);
  localparam logic [ROW_WIDTH-1:0] ROT_X_RESET = {{(2 * COEF_WIDTH){1'b0}}, UNITY};
  localparam logic [ROW_WIDTH-1:0] ROT_Y_RESET =
    {{COEF_WIDTH{1'b0}}, UNITY, {COEF_WIDTH{1'b0}}};
  localparam logic [ROW_WIDTH-1:0] ROT_Z_RESET = {UNITY, {(2 * COEF_WIDTH){1'b0}}};

  localparam logic [IDX_WIDTH-1:0] REG_ROT_X   = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [IDX_WIDTH-1:0] REG_SHIFT_Z = 3'd5;

  typedef struct packed {
    logic [RAD_WIDTH-1:0]  rad;
    logic [REM_WIDTH-1:0]  rem;
    logic [ROOT_WIDTH-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CORD_WIDTH-1:0] a;
    logic signed [CORD_WIDTH-1:0] b;
    logic [TURN_WIDTH-1:0]        acc;
  } cord_t;

  typedef struct packed {
    logic                          skip;
    logic                          sat;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [VEC_WIDTH-1:0]   b;
  } side_t;

  typedef struct packed {
    logic                   skip;
    logic                   sat;
    logic [COORD_WIDTH-1:0] rng;
    logic [1:0]             zero;
  } cside_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [TURN_WIDTH-1:0] atan_turn(input logic [STEP_WIDTH-1:0] i);
    logic [TURN_WIDTH-1:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [BL_WIDTH-1:0] bit_len(input logic [VEC_WIDTH-1:0] v);
    logic [BL_WIDTH-1:0] n;
    n = '0;
    for (int i = 0; i < VEC_WIDTH; i++) begin
      if (v[i]) n = BL_WIDTH'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/c2s_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One restoring square-root step: retires two radicand bits per cycle while en is high.
// ----------------------------------------------------------------------------
module c2s_sqrt_cell import c2s_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d_in,
  output sqrt_t d_out
);

  logic [REM_WIDTH+1:0]  rem_sh;
  logic [REM_WIDTH+1:0]  trial;
  sqrt_t                 nxt;

  always_comb begin
    rem_sh  = {d_in.rem, d_in.rad[RAD_WIDTH-1 -: 2]};
    trial   = (REM_WIDTH + 2)'({d_in.root, 2'b01});
    nxt.rad = {d_in.rad[RAD_WIDTH-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = REM_WIDTH'(rem_sh - trial);
      nxt.root = {d_in.root[ROOT_WIDTH-2:0], 1'b1};
    end else begin
      nxt.rem  = REM_WIDTH'(rem_sh);
      nxt.root = {d_in.root[ROOT_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== rtl/c2s_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One vectoring CORDIC micro-rotation, driving the second component to zero.
// ----------------------------------------------------------------------------
module c2s_cordic_cell import c2s_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [STEP_WIDTH-1:0] step,
  input  cord_t                 d_in,
  output cord_t                 d_out
);

  logic signed [CORD_WIDTH-1:0] da;
  logic signed [CORD_WIDTH-1:0] db;
  logic [TURN_WIDTH-1:0]        ang;
  cord_t                        nxt;

  always_comb begin
    da  = d_in.b >>> step;
    db  = d_in.a >>> step;
    ang = atan_turn(step);
    if (!d_in.b[CORD_WIDTH-1]) begin
      nxt.a   = d_in.a + da;
      nxt.b   = d_in.b - db;
      nxt.acc = d_in.acc + ang;
    end else begin
      nxt.a   = d_in.a - da;
      nxt.b   = d_in.b + db;
      nxt.acc = d_in.acc - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== rtl/cartesian_to_spherical_projector.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_spherical_projector
// The pipeline is 73 registers deep, from the stage that accepts a request to the
// output register that presents its result.
// Throughput: one request per cycle; the whole pipeline advances together
// and holds only while a finished result waits on the output.
// Reset clears all valid flags and loads the identity rotation, zero shift.
// ----------------------------------------------------------------------------
`include "cartesian_to_spherical_projector_defines.svh"

module cartesian_to_spherical_projector import c2s_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [IDX_WIDTH-1:0]          cfg_index,
  input  logic [CFG_WIDTH-1:0]          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ANGLE_WIDTH-1:0]        azimuth,
  output logic signed [ANGLE_WIDTH-1:0] elevation,
  output logic [COORD_WIDTH-1:0]        range,
  output logic                          skipped,
  output logic                          saturated
);

  localparam logic signed [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(2 ** (ANGLE_WIDTH - 2));

  logic en;

  // Configuration registers.
  logic [ROW_WIDTH-1:0]          rot    [3];
  logic signed [SHIFT_WIDTH-1:0] tshift [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0]    <= ROT_X_RESET;
      rot[1]    <= ROT_Y_RESET;
      rot[2]    <= ROT_Z_RESET;
      tshift[0] <= '0;
      tshift[1] <= '0;
      tshift[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_X:   rot[0]    <= cfg_data[ROW_WIDTH-1:0];
        REG_ROT_Y:   rot[1]    <= cfg_data[ROW_WIDTH-1:0];
        REG_ROT_Z:   rot[2]    <= cfg_data[ROW_WIDTH-1:0];
        REG_SHIFT_X: tshift[0] <= cfg_data[SHIFT_WIDTH-1:0];
        REG_SHIFT_Y: tshift[1] <= cfg_data[SHIFT_WIDTH-1:0];
        REG_SHIFT_Z: tshift[2] <= cfg_data[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline stalls as a whole only when the output holds an untaken result.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid flags of the front stages and the two cell chains.
  logic                  v1, v2, v3, v4, v5, v6, v7, vf, vn2, vn3;
  logic [SQRT_STEPS:0]   sv;
  logic [CORDIC_STEPS:0] cv;

  assign sv[0] = v7;
  assign cv[0] = vn3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; vf <= 1'b0; vn2 <= 1'b0; vn3 <= 1'b0;
      sv[SQRT_STEPS:1]   <= '0;
      cv[CORDIC_STEPS:1] <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5; v7 <= v6;
      sv[SQRT_STEPS:1] <= sv[SQRT_STEPS-1:0];
      vf  <= sv[SQRT_STEPS];
      vn2 <= vf;
      vn3 <= vn2;
      cv[CORDIC_STEPS:1] <= cv[CORDIC_STEPS-1:0];
      out_valid <= cv[CORDIC_STEPS];
    end
  end

  // Stage 1: coefficient products.
  logic signed [COORD_WIDTH-1:0] pin  [3];
  logic signed [COEF_WIDTH-1:0]  coef [3][3];
  logic signed [PROD_WIDTH-1:0]  prod1 [3][3];
  logic                          skip1;

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = $signed(rot[r][COEF_WIDTH*c +: COEF_WIDTH]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skip1 <= (point_x == '0) && (point_y == '0) && (point_z == '0);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod1[r][c] <= coef[r][c] * pin[c];
        end
      end
    end
  end

  // Stage 2: row sums with the rounding half added.
  logic signed [SUM_WIDTH-1:0] sum2 [3];
  logic                        skip2;

  always_ff @(posedge clk) begin
    if (en) begin
      skip2 <= skip1;
      for (int r = 0; r < 3; r++) begin
        sum2[r] <= SUM_WIDTH'(prod1[r][0]) + SUM_WIDTH'(prod1[r][1])
                 + SUM_WIDTH'(prod1[r][2]) + SUM_WIDTH'(ROUND_HALF);
      end
    end
  end

  // Stage 3: scale, translate and clamp.
  logic signed [TSUM_WIDTH-1:0]  tsum  [3];
  logic signed [COORD_WIDTH-1:0] clip  [3];
  logic [2:0]                    clamp;
  logic signed [COORD_WIDTH-1:0] coord3 [3];
  logic                          skip3, sat3;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tsum[r] = TSUM_WIDTH'(sum2[r] >>> COEF_FRAC) + TSUM_WIDTH'(tshift[r]);
      if (tsum[r] > TSUM_WIDTH'(COORD_MAX)) begin
        clip[r]  = COORD_WIDTH'(COORD_MAX);
        clamp[r] = 1'b1;
      end else if (tsum[r] < TSUM_WIDTH'(COORD_MIN)) begin
        clip[r]  = COORD_WIDTH'(COORD_MIN);
        clamp[r] = 1'b1;
      end else begin
        clip[r]  = COORD_WIDTH'(tsum[r]);
        clamp[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skip3 <= skip2 || ((clip[0] == '0) && (clip[1] == '0) && (clip[2] == '0));
      sat3  <= |clamp;
      for (int r = 0; r < 3; r++) begin
        coord3[r] <= clip[r];
      end
    end
  end

  // Stage 4: squares.
  logic [SQ_WIDTH-1:0]           sq4    [3];
  logic signed [COORD_WIDTH-1:0] coord4 [3];
  logic                          skip4, sat4;

  always_ff @(posedge clk) begin
    if (en) begin
      skip4 <= skip3;
      sat4  <= sat3;
      for (int r = 0; r < 3; r++) begin
        sq4[r]    <= coord3[r] * coord3[r];
        coord4[r] <= coord3[r];
      end
    end
  end

  // Stage 5: horizontal energy.
  logic [SQ_WIDTH-1:0]           s2_5, yy5;
  logic signed [COORD_WIDTH-1:0] coord5 [3];
  logic                          skip5, sat5;

  always_ff @(posedge clk) begin
    if (en) begin
      skip5 <= skip4;
      sat5  <= sat4;
      s2_5  <= sq4[0] + sq4[2];
      yy5   <= sq4[1];
      for (int r = 0; r < 3; r++) begin
        coord5[r] <= coord4[r];
      end
    end
  end

  // Stage 6: total energy and the elevation pre-scale.
  logic [BL_WIDTH-1:0]           bl5, kfull;
  logic [SQ_WIDTH-1:0]           s2_6, s3_6;
  logic [STEP_WIDTH-1:0]         k6;
  logic signed [COORD_WIDTH-1:0] coord6 [3];
  logic                          skip6, sat6;

  assign bl5   = bit_len(VEC_WIDTH'(s2_5));
  assign kfull = BL_WIDTH'(RAD_WIDTH) - bl5;

  always_ff @(posedge clk) begin
    if (en) begin
      skip6 <= skip5;
      sat6  <= sat5;
      s2_6  <= s2_5;
      s3_6  <= s2_5 + yy5;
      k6    <= kfull[BL_WIDTH-1:1];
      for (int r = 0; r < 3; r++) begin
        coord6[r] <= coord5[r];
      end
    end
  end

  // Stage 7 feeds both square-root chains.
  sqrt_t sqr7, sqe7;
  side_t sd [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sqr7.rad  <= RAD_WIDTH'(s3_6);
      sqr7.rem  <= '0;
      sqr7.root <= '0;
      sqe7.rad  <= RAD_WIDTH'(s2_6) << {k6, 1'b0};
      sqe7.rem  <= '0;
      sqe7.root <= '0;
      sd[0].skip <= skip6;
      sd[0].sat  <= sat6;
      sd[0].x    <= coord6[0];
      sd[0].z    <= coord6[2];
      sd[0].b    <= VEC_WIDTH'(coord6[1]) <<< k6;
      for (int i = 1; i <= SQRT_STEPS; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  sqrt_t sqr_in [SQRT_STEPS];
  sqrt_t sqr_out[SQRT_STEPS];
  sqrt_t sqe_in [SQRT_STEPS];
  sqrt_t sqe_out[SQRT_STEPS];

  assign sqr_in[0] = sqr7;
  assign sqe_in[0] = sqe7;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    if (g > 0) begin : g_link
      assign sqr_in[g] = sqr_out[g-1];
      assign sqe_in[g] = sqe_out[g-1];
    end
    c2s_sqrt_cell u_range (.clk(clk), .en(en), .d_in(sqr_in[g]), .d_out(sqr_out[g]));
    c2s_sqrt_cell u_horiz (.clk(clk), .en(en), .d_in(sqe_in[g]), .d_out(sqe_out[g]));
  end

  // Stage F: range rounding and the half-turn fold of both vectors.
  logic [ROOT_WIDTH:0]           rnd;
  logic [COORD_WIDTH-1:0]        rng_c;
  logic signed [VEC_WIDTH-1:0]   va [2];
  logic signed [VEC_WIDTH-1:0]   vb [2];
  logic signed [VEC_WIDTH-1:0]   fa_c [2];
  logic signed [VEC_WIDTH-1:0]   fb_c [2];
  logic [1:0]                    half_c;

  always_comb begin
    rnd = {1'b0, sqr_out[SQRT_STEPS-1].root}
        + (ROOT_WIDTH + 1)'(sqr_out[SQRT_STEPS-1].rem >
                            REM_WIDTH'(sqr_out[SQRT_STEPS-1].root));
    if (rnd > (ROOT_WIDTH + 1)'({COORD_WIDTH{1'b1}})) begin
      rng_c = '1;
    end else begin
      rng_c = COORD_WIDTH'(rnd);
    end
    va[0] = -VEC_WIDTH'(sd[SQRT_STEPS].z);
    vb[0] = VEC_WIDTH'(sd[SQRT_STEPS].x);
    va[1] = $signed(VEC_WIDTH'(sqe_out[SQRT_STEPS-1].root));
    vb[1] = sd[SQRT_STEPS].b;
    for (int l = 0; l < 2; l++) begin
      if (va[l] < 0) begin
        fa_c[l]   = -va[l];
        fb_c[l]   = -vb[l];
        half_c[l] = 1'b1;
      end else begin
        fa_c[l]   = va[l];
        fb_c[l]   = vb[l];
        half_c[l] = 1'b0;
      end
    end
  end

  logic signed [VEC_WIDTH-1:0] fa [2];
  logic signed [VEC_WIDTH-1:0] fb [2];
  logic [1:0]                  half_f, zero_f;
  logic [COORD_WIDTH-1:0]      rng_f;
  logic                        skip_f, sat_f;

  always_ff @(posedge clk) begin
    if (en) begin
      rng_f  <= rng_c;
      skip_f <= sd[SQRT_STEPS].skip;
      sat_f  <= sd[SQRT_STEPS].sat;
      half_f <= half_c;
      for (int l = 0; l < 2; l++) begin
        fa[l]     <= fa_c[l];
        fb[l]     <= fb_c[l];
        zero_f[l] <= (va[l] == '0) && (vb[l] == '0);
      end
    end
  end

  // Stage N2: magnitude bit length.
  logic signed [VEC_WIDTH-1:0] mb_c [2];
  logic signed [VEC_WIDTH-1:0] m_c  [2];
  logic signed [VEC_WIDTH-1:0] a2 [2];
  logic signed [VEC_WIDTH-1:0] b2 [2];
  logic [BL_WIDTH-1:0]         bl2 [2];
  logic [1:0]                  half2, zero2;
  logic [COORD_WIDTH-1:0]      rng2;
  logic                        skip2n, sat2n;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mb_c[l] = (fb[l] < 0) ? -fb[l] : fb[l];
      m_c[l]  = (fa[l] > mb_c[l]) ? fa[l] : mb_c[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rng2   <= rng_f;
      skip2n <= skip_f;
      sat2n  <= sat_f;
      half2  <= half_f;
      zero2  <= zero_f;
      for (int l = 0; l < 2; l++) begin
        a2[l]  <= fa[l];
        b2[l]  <= fb[l];
        bl2[l] <= bit_len(m_c[l]);
      end
    end
  end

  // Stage N3: scale the larger component into [2^29, 2^30).
  logic signed [VEC_WIDTH-1:0] sa_c [2];
  logic signed [VEC_WIDTH-1:0] sb_c [2];
  cord_t                       n3 [2];
  cside_t                      sc [CORDIC_STEPS+1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (bl2[l] > BL_WIDTH'(NORM_BL)) begin
        sa_c[l] = a2[l] >>> (bl2[l] - BL_WIDTH'(NORM_BL));
        sb_c[l] = b2[l] >>> (bl2[l] - BL_WIDTH'(NORM_BL));
      end else begin
        sa_c[l] = a2[l] <<< (BL_WIDTH'(NORM_BL) - bl2[l]);
        sb_c[l] = b2[l] <<< (BL_WIDTH'(NORM_BL) - bl2[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        n3[l].a   <= CORD_WIDTH'(sa_c[l]);
        n3[l].b   <= CORD_WIDTH'(sb_c[l]);
        n3[l].acc <= half2[l] ? HALF_TURN : '0;
      end
      sc[0].skip <= skip2n;
      sc[0].sat  <= sat2n;
      sc[0].rng  <= rng2;
      sc[0].zero <= zero2;
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        sc[i] <= sc[i-1];
      end
    end
  end

  // CORDIC chains: lane 0 is azimuth, lane 1 is elevation.
  cord_t cd_in  [2][CORDIC_STEPS];
  cord_t cd_out [2][CORDIC_STEPS];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign cd_in[l][0] = n3[l];
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      if (g > 0) begin : g_link
        assign cd_in[l][g] = cd_out[l][g-1];
      end
      c2s_cordic_cell u_cell (
        .clk  (clk),
        .en   (en),
        .step (STEP_WIDTH'(g)),
        .d_in (cd_in[l][g]),
        .d_out(cd_out[l][g])
      );
    end
  end

  // Output stage: a zero vector reads as half a turn; skipped requests give zeros.
  logic [TURN_WIDTH-1:0] acc_c [2];
  logic [TURN_WIDTH-1:0] rd_c  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      acc_c[l] = sc[CORDIC_STEPS].zero[l] ? HALF_TURN : cd_out[l][CORDIC_STEPS-1].acc;
      rd_c[l]  = acc_c[l] + ANGLE_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      skipped <= sc[CORDIC_STEPS].skip;
      if (sc[CORDIC_STEPS].skip) begin
        azimuth   <= '0;
        elevation <= '0;
        range     <= '0;
        saturated <= 1'b0;
      end else begin
        azimuth   <= rd_c[0][TURN_WIDTH-1 -: ANGLE_WIDTH];
        elevation <= rd_c[1][TURN_WIDTH-1 -: ANGLE_WIDTH];
        range     <= sc[CORDIC_STEPS].rng;
        saturated <= sc[CORDIC_STEPS].sat;
      end
    end
  end

  `C2S_ASSERT_IMP(a_skip_zero, out_valid && skipped,
    azimuth == '0 && elevation == '0 && range == '0 && !saturated,
    "skipped request carries nonzero results")
  `C2S_ASSERT_IMP(a_elev_bound, out_valid,
    elevation <= QUARTER && elevation >= -QUARTER, "elevation beyond a quarter turn")
  `C2S_ASSERT_IMP(a_range_nonzero, out_valid && !skipped, range != '0,
    "zero range on a request that was not skipped")
  `C2S_ASSERT_NEXT(a_drain, en && cv[CORDIC_STEPS], out_valid,
    "finished request did not reach the output")

endmodule
